// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion helpers
// Clocked, reset-qualified wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, ck, rstn, prop)
`define ASSERT_NEVER(lbl, ck, rstn, prop)
`endif
`endif

// ----- sv/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg - shared types and constants of the voice mixer
// Command codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svm_pkg;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 40;

  localparam logic [15:0] BLOCK_FRAMES_RST = 16'd4096;
  localparam int          GAIN_SHIFT       = 14;
  localparam int          FADE_SHIFT       = 43;
  // ceil(2^43 / 11025): exact floor division for dividends below 2^29
  localparam logic [29:0] FADE_RECIP       = 30'd797831567;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_FADE   = 3'd3,
    CMD_RENDER = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_VCHK, S_RDL, S_RDR, S_MULR, S_ACC, S_MOD, S_MODWR,
    S_FMUL1, S_FMUL2, S_FAPPLY, S_NEXT, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic render_clr;
    logic rd_l;
    logic rd_r;
    logic mul_l;
    logic mul_r;
    logic acc_l;
    logic acc_r;
    logic pos_keep;
    logic pos_lb;
    logic pos_mod;
    logic stop_cur;
    logic mod_init;
    logic mod_step;
    logic fade_mul1;
    logic fade_mul2;
    logic fade_apply;
    logic v_inc;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic is_render;
    logic cur_active;
    logic wrap;
    logic looped;
    logic lb_lt;
    logic mod_last;
    logic last_voice;
    logic block_end;
  } sts_t;

endpackage

// ----- sv/sample_voice_mixer.sv -----
// ----------------------------------------------------------------------------
// sample_voice_mixer - multi-voice PCM sample playback mixer
// Write, start, stop and fade: capture, execute, load result; one word at a time.
// Render walks the voice table and mixes each active voice; a looped voice that
// wraps takes a remainder step, and a block end adds a fade step.
// Synchronous active-low reset clears the voice active flags and sets block_frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sample_voice_mixer import svm_pkg::*; #(
  parameter int VOICES        = 16,
  parameter int SAMPLE_DEPTH  = 65536,  // power of two
  parameter int FRACTION_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // command words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // voice, start_address, value, end_frame, loop_start, looped, stereo,
  // left_volume, right_volume, playback_step, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [2:0]             in_tuser,  // command
  input  logic                   in_tlast,  // block_end
  // result words
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // left_out, right_out, voice_slot, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser, // accepted
  // block_frames register
  input  logic                   cfg_wen,
  input  logic [15:0]            cfg_wdata
);

  ctl_t ctl;
  sts_t sts;

  // The sequencer takes one word at a time; the result sits in an output
  // register so the next word can be accepted while it waits.
  svm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  // Sample memory, voice table, multipliers, loop remainder and fade maths.
  svm_datapath #(
    .VOICES        (VOICES),
    .SAMPLE_DEPTH  (SAMPLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // one word in flight: ready drops right after an accept
  `ASSERT_AT(a_one_in_flight, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)
  // never overwrite a result that is still waiting
  `ASSERT_AT(a_out_load_free, clk, rst_n, ctl.out_load |-> (!out_tvalid || out_tready))
  // at most one position update per cycle
  `ASSERT_AT(a_pos_onehot, clk, rst_n, $onehot0({ctl.pos_keep, ctl.pos_lb, ctl.pos_mod}))

endmodule

// ----- sv/svm_ctrl.sv -----
// ----------------------------------------------------------------------------
// svm_ctrl - sequencer of the voice mixer
// Walks one command at a time and holds the output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svm_ctrl import svm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = sts.is_render ? S_VCHK : S_DONE;
      S_VCHK:   state_nxt = sts.cur_active ? S_RDL : S_NEXT;
      S_RDL:    state_nxt = S_RDR;
      S_RDR:    state_nxt = S_MULR;
      S_MULR:   state_nxt = S_ACC;
      S_ACC: begin
        if (sts.wrap && !sts.looped) state_nxt = S_NEXT;
        else if (sts.wrap && sts.lb_lt) state_nxt = S_MOD;
        else state_nxt = sts.block_end ? S_FMUL1 : S_NEXT;
      end
      S_MOD:    if (sts.mod_last) state_nxt = S_MODWR;
      S_MODWR:  state_nxt = sts.block_end ? S_FMUL1 : S_NEXT;
      S_FMUL1:  state_nxt = S_FMUL2;
      S_FMUL2:  state_nxt = S_FAPPLY;
      S_FAPPLY: state_nxt = S_NEXT;
      S_NEXT:   state_nxt = sts.last_voice ? S_DONE : S_VCHK;
      S_DONE:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_IDLE:   ctl.load = in_tvalid;
      S_EXEC: begin
        ctl.exec       = !sts.is_render;
        ctl.render_clr = sts.is_render;
      end
      S_VCHK:   ;
      S_RDL:    ctl.rd_l = 1'b1;
      S_RDR: begin
        ctl.rd_r  = 1'b1;
        ctl.mul_l = 1'b1;
      end
      S_MULR: begin
        ctl.mul_r = 1'b1;
        ctl.acc_l = 1'b1;
      end
      S_ACC: begin
        ctl.acc_r = 1'b1;
        if (sts.wrap && !sts.looped) begin
          ctl.pos_keep = 1'b1;
          ctl.stop_cur = 1'b1;
        end else if (sts.wrap && sts.lb_lt) begin
          ctl.mod_init = 1'b1;
        end else if (sts.wrap) begin
          ctl.pos_lb = 1'b1;
        end else begin
          ctl.pos_keep = 1'b1;
        end
      end
      S_MOD:    ctl.mod_step   = 1'b1;
      S_MODWR:  ctl.pos_mod    = 1'b1;
      S_FMUL1:  ctl.fade_mul1  = 1'b1;
      S_FMUL2:  ctl.fade_mul2  = 1'b1;
      S_FAPPLY: ctl.fade_apply = 1'b1;
      S_NEXT:   ctl.v_inc      = !sts.last_voice;
      S_DONE:   ctl.out_load   = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ----- sv/svm_datapath.sv -----
// ----------------------------------------------------------------------------
// svm_datapath - sample memory, voice table and mixing arithmetic
// Acts on controller commands; reports status flags back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svm_datapath import svm_pkg::*; #(
  parameter int VOICES        = 16,
  parameter int SAMPLE_DEPTH  = 65536,
  parameter int FRACTION_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctl_t                   ctl,
  output sts_t                   sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [2:0]             in_tuser,
  input  logic                   in_tlast,
  input  logic                   cfg_wen,
  input  logic [15:0]            cfg_wdata,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  localparam int VIW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW   = $clog2(SAMPLE_DEPTH);
  localparam int SW   = (AW > 18) ? AW : 18;
  localparam int PW   = 16 + FRACTION_BITS;
  localparam int QB   = 17 - FRACTION_BITS;
  localparam int DW   = PW + QB;
  localparam int MCW  = $clog2(QB + 1);
  localparam int ACCW = 19 + VIW;

  // captured word
  logic [2:0]  cmd_r;
  logic [3:0]  voice_r;
  logic [15:0] addr_r, value_r, end_r, loop_r, lvol_r, rvol_r, step_r;
  logic        looped_r, stereo_r, bend_r;
  logic [15:0] block_frames_r;

  // voice table
  logic [VOICES-1:0] act_r;
  logic              looped_a [VOICES];
  logic              stereo_a [VOICES];
  logic [15:0]       base_a   [VOICES];
  logic [15:0]       end_a    [VOICES];
  logic [15:0]       loop_a   [VOICES];
  logic [PW-1:0]     pos_a    [VOICES];
  logic [15:0]       gl_a     [VOICES];
  logic [15:0]       gr_a     [VOICES];
  logic [15:0]       step_a   [VOICES];
  logic [15:0]       fade_a   [VOICES];

  logic [15:0] mem [SAMPLE_DEPTH];
  logic [15:0] rd_data_r;

  logic [VIW-1:0]        v_r;
  logic signed [32:0]    prod_l_r, prod_r_r;
  logic signed [ACCW-1:0] lsum_r, rsum_r;
  logic [PW:0]           pos_sum_r;
  logic [15:0]           rem_r;
  logic [DW-1:0]         dsh_r;
  logic [MCW-1:0]        mcnt_r;
  logic signed [30:0]    fprod_r;
  logic                  fneg_r;
  logic [58:0]           fmul_r;
  logic [3:0]            res_slot_r;
  logic                  res_acc_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;

  // free slot search and addressed slot
  logic           free_found;
  logic [VIW-1:0] free_idx;
  logic [VIW-1:0] vsel;
  logic           voice_ok;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_found = 1'b1;
        free_idx   = VIW'(i);
      end
    end
  end

  assign vsel     = VIW'(voice_r);
  assign voice_ok = (32'(voice_r) < VOICES);

  // current voice
  logic          stereo_cur, looped_cur;
  logic [15:0]   base_cur, end_cur, loop_cur, gl_cur, gr_cur, step_cur, fade_cur;
  logic [PW-1:0] pos_cur, endp, lb, span;
  logic [15:0]   frame;
  logic [16:0]   off;
  logic [SW-1:0] a0, a1, a_sel;

  assign stereo_cur = stereo_a[v_r];
  assign looped_cur = looped_a[v_r];
  assign base_cur   = base_a[v_r];
  assign end_cur    = end_a[v_r];
  assign loop_cur   = loop_a[v_r];
  assign gl_cur     = gl_a[v_r];
  assign gr_cur     = gr_a[v_r];
  assign step_cur   = step_a[v_r];
  assign fade_cur   = fade_a[v_r];
  assign pos_cur    = pos_a[v_r];

  assign endp  = {end_cur, FRACTION_BITS'(0)};
  assign lb    = {loop_cur, FRACTION_BITS'(0)};
  assign span  = endp - lb;
  assign frame = pos_cur[PW-1:FRACTION_BITS];
  assign off   = stereo_cur ? {frame, 1'b0} : {1'b0, frame};
  assign a0    = SW'(base_cur) + SW'(off);
  assign a1    = a0 + SW'(stereo_cur);
  assign a_sel = ctl.rd_l ? a0 : a1;

  logic [SW-1:0] waddr;
  assign waddr = SW'(addr_r);

  // scaled contributions
  logic signed [18:0] contrib_l, contrib_r;
  assign contrib_l = 19'(prod_l_r >>> GAIN_SHIFT);
  assign contrib_r = 19'(prod_r_r >>> GAIN_SHIFT);

  // remainder step
  logic          rem_ge;
  logic [DW-1:0] rem_sub;
  assign rem_ge  = (DW'(rem_r) >= dsh_r);
  assign rem_sub = DW'(rem_r) - dsh_r;

  // fade arithmetic
  logic signed [14:0] half;
  logic [28:0]        fmag;
  logic [15:0]        fq;
  logic signed [17:0] dec, gl_diff, gr_diff;
  logic [15:0]        gl_new, gr_new;

  function automatic logic [15:0] sat_gain(input logic signed [17:0] d);
    logic [15:0] r;
    if (d < 0) r = 16'd0;
    else if (d > 18'sd65535) r = 16'hffff;
    else r = d[15:0];
    return r;
  endfunction

  function automatic logic [15:0] clamp16(input logic signed [ACCW-1:0] s);
    logic [15:0] r;
    if (s > ACCW'(SAMPLE_MAX)) r = SAMPLE_MAX;
    else if (s < ACCW'(SAMPLE_MIN)) r = SAMPLE_MIN;
    else r = s[15:0];
    return r;
  endfunction

  assign half    = $signed(fade_cur[15:1]);
  assign fmag    = fprod_r[30] ? 29'(-fprod_r) : 29'(fprod_r);
  assign fq      = fmul_r[58:FADE_SHIFT];
  assign dec     = fneg_r ? -$signed({2'b00, fq}) : $signed({2'b00, fq});
  assign gl_diff = $signed({2'b00, gl_cur}) - dec;
  assign gr_diff = $signed({2'b00, gr_cur}) - dec;
  assign gl_new  = sat_gain(gl_diff);
  assign gr_new  = sat_gain(gr_diff);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r          <= '0;
      block_frames_r <= BLOCK_FRAMES_RST;
    end else begin
      if (cfg_wen) block_frames_r <= cfg_wdata;
      if (ctl.exec && cmd_r == CMD_START && free_found) act_r[free_idx] <= 1'b1;
      if (ctl.exec && cmd_r == CMD_STOP && voice_ok) act_r[vsel] <= 1'b0;
      if (ctl.stop_cur) act_r[v_r] <= 1'b0;
      if (ctl.fade_apply && gl_new == 16'd0 && gr_new == 16'd0) act_r[v_r] <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r      <= in_tuser;
      voice_r    <= in_tdata[3:0];
      addr_r     <= in_tdata[19:4];
      value_r    <= in_tdata[35:20];
      end_r      <= in_tdata[51:36];
      loop_r     <= in_tdata[67:52];
      looped_r   <= in_tdata[68];
      stereo_r   <= in_tdata[69];
      lvol_r     <= in_tdata[85:70];
      rvol_r     <= in_tdata[101:86];
      step_r     <= in_tdata[117:102];
      bend_r     <= in_tlast;
      res_slot_r <= 4'd0;
      res_acc_r  <= 1'b0;
    end
    if (ctl.exec) begin
      case (cmd_r)
        CMD_WRITE: res_acc_r <= 1'b1;
        CMD_START: begin
          if (free_found) begin
            looped_a[free_idx] <= looped_r;
            stereo_a[free_idx] <= stereo_r;
            base_a[free_idx]   <= addr_r;
            end_a[free_idx]    <= end_r;
            loop_a[free_idx]   <= loop_r;
            gl_a[free_idx]     <= lvol_r;
            gr_a[free_idx]     <= rvol_r;
            step_a[free_idx]   <= step_r;
            pos_a[free_idx]    <= '0;
            fade_a[free_idx]   <= 16'd0;
            res_slot_r         <= 4'(free_idx);
            res_acc_r          <= 1'b1;
          end
        end
        CMD_STOP: res_acc_r <= voice_ok;
        CMD_FADE: begin
          if (voice_ok) fade_a[vsel] <= value_r;
          res_acc_r <= voice_ok;
        end
        default: ;
      endcase
    end
    if (ctl.render_clr) begin
      lsum_r <= '0;
      rsum_r <= '0;
      v_r    <= '0;
    end
    if (ctl.v_inc) v_r <= v_r + 1'b1;
    if (ctl.mul_l) prod_l_r <= $signed(rd_data_r) * $signed({1'b0, gl_cur});
    if (ctl.mul_r) begin
      prod_r_r  <= $signed(rd_data_r) * $signed({1'b0, gr_cur});
      pos_sum_r <= {1'b0, pos_cur} + (PW + 1)'(step_cur);
    end
    if (ctl.acc_l) lsum_r <= lsum_r + ACCW'(contrib_l);
    if (ctl.acc_r) rsum_r <= rsum_r + ACCW'(contrib_r);
    if (ctl.pos_keep) pos_a[v_r] <= pos_sum_r[PW-1:0];
    if (ctl.pos_lb) pos_a[v_r] <= lb;
    if (ctl.pos_mod) pos_a[v_r] <= lb + PW'(rem_r);
    if (ctl.mod_init) begin
      rem_r  <= 16'(pos_sum_r - {1'b0, endp});
      dsh_r  <= DW'(span) << (QB - 1);
      mcnt_r <= '0;
    end
    if (ctl.mod_step) begin
      if (rem_ge) rem_r <= rem_sub[15:0];
      dsh_r  <= dsh_r >> 1;
      mcnt_r <= mcnt_r + 1'b1;
    end
    if (ctl.fade_mul1) fprod_r <= half * $signed({1'b0, block_frames_r[15:1]});
    if (ctl.fade_mul2) begin
      fmul_r <= 59'(fmag) * 59'(FADE_RECIP);
      fneg_r <= fprod_r[30];
    end
    if (ctl.fade_apply) begin
      gl_a[v_r] <= gl_new;
      gr_a[v_r] <= gr_new;
    end
    if (ctl.out_load) begin
      if (cmd_r == CMD_RENDER) begin
        out_tdata_r <= {4'd0, 4'd0, clamp16(rsum_r), clamp16(lsum_r)};
        out_tuser_r <= 1'b1;
      end else begin
        out_tdata_r <= {4'd0, res_slot_r, 32'd0};
        out_tuser_r <= res_acc_r;
      end
    end
  end

  // sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.exec && cmd_r == CMD_WRITE) mem[waddr[AW-1:0]] <= value_r;
    if (ctl.rd_l || ctl.rd_r) rd_data_r <= mem[a_sel[AW-1:0]];
  end

  assign sts.is_render  = (cmd_r == CMD_RENDER);
  assign sts.cur_active = act_r[v_r];
  assign sts.wrap       = (pos_sum_r >= {1'b0, endp});
  assign sts.looped     = looped_cur;
  assign sts.lb_lt      = (loop_cur < end_cur);
  assign sts.mod_last   = (mcnt_r == MCW'(QB - 1));
  assign sts.last_voice = (v_r == VIW'(VOICES - 1));
  assign sts.block_end  = bend_r;

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule
